// ----- hw/rtl/csvfb_pkg.sv -----
// ----------------------------------------------------------------------------
// csvfb_pkg
// Shared types, constants and register codes for the CSV field boundary
// scanner.
// ----------------------------------------------------------------------------
package csvfb_pkg;

    // Fixed field widths of the channels
    localparam int WORD_WIDTH      = 64;
    localparam int COUNT_WIDTH     = 4;
    localparam int OFFSET_WIDTH    = 32;
    localparam int LENGTH_WIDTH    = 32;
    localparam int COL_WIDTH       = 11;
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 16;

    // Parameter defaults
    localparam int DEFAULT_BYTES_PER_WORD = 8;
    localparam int DEFAULT_POSITION_WIDTH = 32;

    // Special bytes
    localparam logic [7:0] QUOTE_BYTE = 8'h22;
    localparam logic [7:0] LF_BYTE    = 8'h0A;
    localparam logic [7:0] CR_BYTE    = 8'h0D;

    // Register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_DELIMITER       = 8'd0,
        REG_QUOTES_ENABLED  = 8'd1,
        REG_MAX_COLUMNS     = 8'd2,
        REG_COUNT_ROWS_ONLY = 8'd3
    } t_reg_index;

    // Register reset values
    localparam logic [7:0]           RST_DELIMITER       = 8'd44;
    localparam logic                 RST_QUOTES_ENABLED  = 1'b1;
    localparam logic [COL_WIDTH-1:0] RST_MAX_COLUMNS     = 11'd1024;
    localparam logic                 RST_COUNT_ROWS_ONLY = 1'b0;

    // Classification of one stream byte
    typedef struct packed {
        logic quote;     // toggles quoted state
        logic delim;     // ends a cell
        logic row_term;  // ends a row
        logic lf_skip;   // LF after CR: moves cell start only
    } t_byte_class;

    // One result
    typedef struct packed {
        logic [OFFSET_WIDTH-1:0] cell_offset;
        logic [LENGTH_WIDTH-1:0] cell_length;
        logic [COL_WIDTH-1:0]    column_index;
        logic                    row_end;
        logic                    cell_kept;
        logic                    row_overflow;
        logic                    last_of_item;
    } t_result;

endpackage

// ----- hw/rtl/csvfb_ifs.sv -----
// ----------------------------------------------------------------------------
// csvfb channel interfaces
// Valid/ready channels for input words, results and register writes.
// ----------------------------------------------------------------------------
interface csvfb_in_if
    import csvfb_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [WORD_WIDTH-1:0]  data_word;
    logic [COUNT_WIDTH-1:0] byte_count;

    modport source (output valid, output data_word, output byte_count, input ready);
    modport sink   (input valid, input data_word, input byte_count, output ready);
endinterface

interface csvfb_out_if
    import csvfb_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [OFFSET_WIDTH-1:0] cell_offset;
    logic [LENGTH_WIDTH-1:0] cell_length;
    logic [COL_WIDTH-1:0]    column_index;
    logic                    row_end;
    logic                    cell_kept;
    logic                    row_overflow;
    logic                    last_of_item;

    modport source (output valid, output cell_offset, output cell_length,
                    output column_index, output row_end, output cell_kept,
                    output row_overflow, output last_of_item, input ready);
    modport sink   (input valid, input cell_offset, input cell_length,
                    input column_index, input row_end, input cell_kept,
                    input row_overflow, input last_of_item, output ready);
endinterface

interface csvfb_cfg_if
    import csvfb_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] reg_index;
    logic [CFG_DATA_WIDTH-1:0]  write_data;

    modport source (output valid, output reg_index, output write_data, input ready);
    modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

// ----- hw/rtl/csv_field_boundary_scanner.sv -----
// Flow: a word of N valid bytes (N saturated to BYTES_PER_WORD) is taken only
//   while idle and fully scanned before the next; a result moves from the
//   pending to the output register once the next boundary in the stream, or
//   the end of its word, has been seen. Scanning runs one byte per cycle
//   through the shared byte classifier unless a boundary waits on the sink.
// Reset: synchronous, active low; state cleared and registers to defaults.
// ----------------------------------------------------------------------------
// csv_field_boundary_scanner
// Scans CSV words byte by byte, tracking quote state, and emits one result
// per cell or row boundary with offset, length and column.
// ----------------------------------------------------------------------------
module csv_field_boundary_scanner
    import csvfb_pkg::*;
#(
    parameter int BYTES_PER_WORD = DEFAULT_BYTES_PER_WORD,
    parameter int POSITION_WIDTH = DEFAULT_POSITION_WIDTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    csvfb_in_if.sink       i_in,
    csvfb_cfg_if.sink      i_cfg,
    csvfb_out_if.source    o_out
);

    localparam int LEFT_W = $clog2(BYTES_PER_WORD + 1);
    localparam int WORD_W = 8 * BYTES_PER_WORD;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    // configuration registers
    logic [7:0]           r_delim;
    logic                 r_qen;
    logic [COL_WIDTH-1:0] r_max_cols;
    logic                 r_rows_only;

    // sequencer
    t_state               r_state;
    logic [WORD_W-1:0]    r_word;    // current byte sits in bits 7:0
    logic [LEFT_W-1:0]    r_left;    // bytes still to scan

    // stream state
    logic                      r_inq;
    logic                      r_prev_cr;
    logic [POSITION_WIDTH-1:0] r_pos;
    logic [POSITION_WIDTH-1:0] r_start;
    logic [COL_WIDTH-1:0]      r_col;
    logic                      r_ovf;

    // pending result: held until we know whether it is the word's last
    logic    r_pend_v;
    t_result r_pend;

    // output register
    logic    r_out_v;
    t_result r_out;

    t_byte_class               cls;
    logic [POSITION_WIDTH-1:0] len;
    logic                      kept;
    logic                      hit;
    logic                      out_free;
    logic                      step;
    logic                      load_out;
    logic [LEFT_W-1:0]         n_left;
    t_result                   n_res;
    t_result                   pend_last;

    csvfb_byte_class u_class (
        .i_byte         (r_word[7:0]),
        .i_delimiter    (r_delim),
        .i_quotes_en    (r_qen),
        .i_inside_quote (r_inq),
        .i_rows_only    (r_rows_only),
        .i_prev_cr      (r_prev_cr),
        .o_class        (cls)
    );

    assign len      = r_pos - r_start;
    assign kept     = r_col < r_max_cols;
    assign hit      = cls.delim || cls.row_term;
    assign out_free = !r_out_v || o_out.ready;
    // a new boundary pushes the pending one out, so it needs a free slot
    assign step     = (r_state == S_SCAN) && (r_left != '0)
                      && !(hit && r_pend_v && !out_free);
    // pending result moves to the output: at end of word, or pushed by a new one
    assign load_out = (r_state == S_SCAN) && r_pend_v
                      && ((r_left == '0) ? out_free : (step && hit));

    // word byte count saturates at the word size
    assign n_left = (i_in.byte_count > COUNT_WIDTH'(BYTES_PER_WORD))
                    ? LEFT_W'(BYTES_PER_WORD) : LEFT_W'(i_in.byte_count);

    always_comb begin
        n_res.cell_offset  = OFFSET_WIDTH'(r_start);
        n_res.cell_length  = LENGTH_WIDTH'(len);
        n_res.last_of_item = 1'b0;
        if (cls.row_term && r_rows_only) begin
            // row counting: no column information
            n_res.column_index = '0;
            n_res.row_end      = 1'b1;
            n_res.cell_kept    = 1'b0;
            n_res.row_overflow = 1'b0;
        end else begin
            n_res.column_index = r_col;
            n_res.row_end      = cls.row_term;
            n_res.cell_kept    = kept;
            n_res.row_overflow = cls.row_term && (r_ovf || !kept);
        end
    end

    // pending result flagged as the word's final one
    always_comb begin
        pend_last              = r_pend;
        pend_last.last_of_item = 1'b1;
    end

    assign i_in.ready  = r_state == S_IDLE;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid        = r_out_v;
    assign o_out.cell_offset  = r_out.cell_offset;
    assign o_out.cell_length  = r_out.cell_length;
    assign o_out.column_index = r_out.column_index;
    assign o_out.row_end      = r_out.row_end;
    assign o_out.cell_kept    = r_out.cell_kept;
    assign o_out.row_overflow = r_out.row_overflow;
    assign o_out.last_of_item = r_out.last_of_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim     <= RST_DELIMITER;
            r_qen       <= RST_QUOTES_ENABLED;
            r_max_cols  <= RST_MAX_COLUMNS;
            r_rows_only <= RST_COUNT_ROWS_ONLY;
            r_state     <= S_IDLE;
            r_left      <= '0;
            r_inq       <= 1'b0;
            r_prev_cr   <= 1'b0;
            r_pos       <= '0;
            r_start     <= '0;
            r_col       <= '0;
            r_ovf       <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            // register writes; unknown indexes are dropped
            if (i_cfg.valid) begin
                case (i_cfg.reg_index)
                    REG_DELIMITER:       r_delim     <= i_cfg.write_data[7:0];
                    REG_QUOTES_ENABLED:  r_qen       <= i_cfg.write_data[0];
                    REG_MAX_COLUMNS:     r_max_cols  <= i_cfg.write_data[COL_WIDTH-1:0];
                    REG_COUNT_ROWS_ONLY: r_rows_only <= i_cfg.write_data[0];
                    default: ;
                endcase
            end

            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && o_out.ready) begin
                r_out_v <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_word  <= i_in.data_word[WORD_W-1:0];
                        r_left  <= n_left;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_left == '0) begin
                        // end of word: pending result is the last one
                        if (!r_pend_v) begin
                            r_state <= S_IDLE;
                        end else if (out_free) begin
                            r_out    <= pend_last;
                            r_pend_v <= 1'b0;
                            r_state  <= S_IDLE;
                        end
                    end else if (step) begin
                        r_word    <= r_word >> 8;
                        r_left    <= r_left - 1'b1;
                        r_prev_cr <= r_word[7:0] == CR_BYTE;
                        r_pos     <= r_pos + 1'b1;
                        if (cls.quote) begin
                            r_inq <= !r_inq;
                        end
                        if (hit) begin
                            if (r_pend_v) begin
                                r_out <= r_pend;
                            end
                            r_pend   <= n_res;
                            r_pend_v <= 1'b1;
                        end
                        if (hit || cls.lf_skip) begin
                            r_start <= r_pos + 1'b1;
                        end
                        if (cls.delim) begin
                            if (kept) begin
                                r_col <= r_col + 1'b1;
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end
                        if (cls.row_term) begin
                            r_col <= '0;
                            r_ovf <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // nothing may be left pending once the sequencer is idle
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("pending result left over at idle");

    // byte counter never exceeds the word size
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= LEFT_W'(BYTES_PER_WORD))
        else $error("byte counter out of range");

    // a cell result carries no overflow flag
    a_cell_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.row_end) |-> !o_out.row_overflow)
        else $error("overflow flagged on a cell result");

    // a word-closing result returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_left == '0 && r_pend_v && out_free)
        |=> (r_state == S_IDLE && o_out.valid && o_out.last_of_item))
        else $error("final result did not close the word");
`endif

endmodule

// ----- hw/rtl/csvfb_byte_class.sv -----
// ----------------------------------------------------------------------------
// csvfb_byte_class
// Classifies one stream byte against quoting state and configuration.
// ----------------------------------------------------------------------------
module csvfb_byte_class
    import csvfb_pkg::*;
(
    input  logic [7:0]  i_byte,
    input  logic [7:0]  i_delimiter,
    input  logic        i_quotes_en,
    input  logic        i_inside_quote,
    input  logic        i_rows_only,
    input  logic        i_prev_cr,
    output t_byte_class o_class
);

    logic is_quote;
    logic skip;
    logic is_delim;
    logic is_cr;
    logic is_lf;

    assign is_quote = i_quotes_en && (i_byte == QUOTE_BYTE);
    // quoted text carries no structure
    assign skip     = is_quote || (i_quotes_en && i_inside_quote);
    assign is_delim = !skip && !i_rows_only && (i_byte == i_delimiter);
    assign is_cr    = i_byte == CR_BYTE;
    assign is_lf    = i_byte == LF_BYTE;

    always_comb begin
        o_class.quote    = is_quote;
        o_class.delim    = is_delim;
        o_class.lf_skip  = !skip && !is_delim && is_lf && i_prev_cr;
        o_class.row_term = !skip && !is_delim && (is_cr || (is_lf && !i_prev_cr));
    end

endmodule
